// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, when true, requires another in the same cycle.
`define ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants of the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam int MCR_COORD_W     = 12;
  localparam int MCR_POINT_W     = 13;
  localparam int MCR_RADIUS_BITS = 10;
  localparam int MCR_DEC_EXTRA   = 4;
  localparam int MCR_QUEUE_DEPTH = 2;

  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // Index of the last point of a step command, by kind.
  localparam logic [2:0] MCR_LAST_FULL  = 3'd7;
  localparam logic [2:0] MCR_LAST_FINAL = 3'd3;
  localparam logic [2:0] MCR_LAST_ZERO  = 3'd0;

  // Kind of step command handed from the front to the back.
  typedef enum logic [1:0] {
    KIND_FULL,
    KIND_FINAL,
    KIND_ZERO
  } mcr_kind_t;

  // Status of the command queue.
  typedef struct packed {
    logic full;
    logic empty;
  } mcr_qstat_t;

endpackage

// ===== rtl/midpoint_circle_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit
// Midpoint circle point generator with queue-style request and result ports.
// ----------------------------------------------------------------------------
// A start request (mode 0) loads the center and radius and produces no
// result; each advance request (mode 1) produces the eight mirrored points of
// the current octant offset, the last four points of the circle, or the
// center alone for radius zero, with step_last on the final point of the
// request and circle_done on the final point of the circle. An advance with
// no circle loaded produces nothing. Requests are taken one per cycle while
// full is low; an advance request then occupies the point expander for its
// eight, four or one points, since that unit writes exactly one point per
// cycle into the result register while the receiver keeps taking points, so
// a steady stream of advances is paced by the expander. The front keeps
// the circle state and updates the decision value in the cycle a request is
// taken, and a short command queue lets it run ahead of the expander.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit
  import mcr_pkg::*;
#(
  parameter int RADIUS_BITS = MCR_RADIUS_BITS,
  parameter int QUEUE_DEPTH = MCR_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request side.
  input  logic                          push,
  output logic                          full,
  input  logic                          in_mode,
  input  logic signed [MCR_COORD_W-1:0] in_center_x,
  input  logic signed [MCR_COORD_W-1:0] in_center_y,
  input  logic [RADIUS_BITS-1:0]        in_radius,
  // Result side.
  output logic                          empty,
  input  logic                          pop,
  output logic signed [MCR_POINT_W-1:0] out_point_x,
  output logic signed [MCR_POINT_W-1:0] out_point_y,
  output logic                          out_step_last,
  output logic                          out_circle_done
);

`include "assert_macros.svh"

  localparam int CMD_W = 2 + 2 * MCR_COORD_W + 2 * RADIUS_BITS;

  // Each queued command carries the step kind, the center and the offset.
  logic             q_push;
  logic             q_pop;
  logic [CMD_W-1:0] q_wdata;
  logic [CMD_W-1:0] q_rdata;
  mcr_qstat_t       qstat;

  mcr_front #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .in_mode     (in_mode),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .qstat       (qstat),
    .full        (full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  mcr_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (q_push),
    .wdata (q_wdata),
    .rd_en (q_pop),
    .rdata (q_rdata),
    .qstat (qstat)
  );

  mcr_back #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .qstat           (qstat),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_step_last   (out_step_last),
    .out_circle_done (out_circle_done)
  );

  // The queue can never report full and empty together.
  `ASSERT_ALWAYS(a_qstat_consistent, !(qstat.full && qstat.empty), "queue full and empty")

  // A start request updates the circle state only and never queues a command.
  `ASSERT_IMPLIES(a_start_no_cmd, push && !full && (in_mode == MODE_START), !q_push, "start queued")

  // The front only writes into a queue that has room.
  `ASSERT_IMPLIES(a_push_room, q_push, !qstat.full, "queue overflow")

  // The end of a circle is always the end of its request.
  `ASSERT_IMPLIES(a_done_last, !empty && out_circle_done, out_step_last, "done without last")

endmodule

// ===== rtl/mcr_front.sv =====
// ----------------------------------------------------------------------------
// mcr_front
// Holds the circle state, classifies requests and queues step commands.
// ----------------------------------------------------------------------------
module mcr_front
  import mcr_pkg::*;
#(
  parameter int RADIUS_BITS = MCR_RADIUS_BITS,
  localparam int CMD_W = 2 + 2 * MCR_COORD_W + 2 * RADIUS_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic                          in_mode,
  input  logic signed [MCR_COORD_W-1:0] in_center_x,
  input  logic signed [MCR_COORD_W-1:0] in_center_y,
  input  logic [RADIUS_BITS-1:0]        in_radius,
  input  mcr_qstat_t                    qstat,
  output logic                          full,
  output logic                          q_push,
  output logic [CMD_W-1:0]              q_wdata
);

  localparam int DEC_W = RADIUS_BITS + MCR_DEC_EXTRA;

  logic [MCR_COORD_W-1:0] org_x_r, org_x_nxt;
  logic [MCR_COORD_W-1:0] org_y_r, org_y_nxt;
  logic [RADIUS_BITS-1:0] off_x_r, off_x_nxt;
  logic [RADIUS_BITS-1:0] off_y_r, off_y_nxt;
  logic [DEC_W-1:0]       dec_r, dec_nxt;
  logic                   active_r, active_nxt;

  logic                   accept;
  logic [DEC_W-1:0]       xe, ye, dec_se, dec_e;
  mcr_kind_t              kind;

  assign full   = qstat.full;
  assign accept = push && !qstat.full;

  assign xe     = DEC_W'(off_x_r);
  assign ye     = DEC_W'(off_y_r);
  assign dec_se = dec_r + ((xe - ye) << 1) + DEC_W'(5);
  assign dec_e  = dec_r + (xe << 1) + DEC_W'(3);

  always_comb begin
    if ((off_x_r == '0) && (off_y_r == '0)) begin
      kind = KIND_ZERO;
    end else if (off_y_r > off_x_r) begin
      kind = KIND_FULL;
    end else begin
      kind = KIND_FINAL;
    end
  end

  assign q_wdata = {kind, org_x_r, org_y_r, off_x_r, off_y_r};

  always_comb begin
    org_x_nxt  = org_x_r;
    org_y_nxt  = org_y_r;
    off_x_nxt  = off_x_r;
    off_y_nxt  = off_y_r;
    dec_nxt    = dec_r;
    active_nxt = active_r;
    q_push     = 1'b0;
    if (accept) begin
      if (in_mode == MODE_START) begin
        org_x_nxt  = in_center_x;
        org_y_nxt  = in_center_y;
        off_x_nxt  = '0;
        off_y_nxt  = in_radius;
        dec_nxt    = DEC_W'(1) - DEC_W'(in_radius);
        active_nxt = 1'b1;
      end else if (active_r) begin
        q_push = 1'b1;
        if (kind == KIND_FULL) begin
          off_x_nxt = off_x_r + RADIUS_BITS'(1);
          if (!dec_r[DEC_W-1]) begin
            dec_nxt   = dec_se;
            off_y_nxt = off_y_r - RADIUS_BITS'(1);
          end else begin
            dec_nxt = dec_e;
          end
        end else begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r  <= '0;
      org_y_r  <= '0;
      off_x_r  <= '0;
      off_y_r  <= '0;
      dec_r    <= '0;
      active_r <= 1'b0;
    end else begin
      org_x_r  <= org_x_nxt;
      org_y_r  <= org_y_nxt;
      off_x_r  <= off_x_nxt;
      off_y_r  <= off_y_nxt;
      dec_r    <= dec_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// ===== rtl/mcr_queue.sv =====
// ----------------------------------------------------------------------------
// mcr_queue
// Short register queue of step commands between the front and the back.
// ----------------------------------------------------------------------------
module mcr_queue
  import mcr_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = MCR_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rdata,
  output mcr_qstat_t       qstat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign qstat.full  = (count_r == CW'(DEPTH));
  assign qstat.empty = (count_r == '0);
  assign rdata       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CW'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/mcr_back.sv =====
// ----------------------------------------------------------------------------
// mcr_back
// Expands each command into its mirrored points, one per cycle while popped.
// ----------------------------------------------------------------------------
module mcr_back
  import mcr_pkg::*;
#(
  parameter int RADIUS_BITS = MCR_RADIUS_BITS,
  localparam int CMD_W = 2 + 2 * MCR_COORD_W + 2 * RADIUS_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mcr_qstat_t                    qstat,
  input  logic [CMD_W-1:0]              q_rdata,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic signed [MCR_POINT_W-1:0] out_point_x,
  output logic signed [MCR_POINT_W-1:0] out_point_y,
  output logic                          out_step_last,
  output logic                          out_circle_done
);

  localparam int SW = (RADIUS_BITS > MCR_POINT_W) ? RADIUS_BITS : MCR_POINT_W;

  logic [CMD_W-1:0]       cmd_r;
  logic                   cmd_valid_r;
  logic [2:0]             idx_r;
  logic                   out_valid_r;
  logic [MCR_POINT_W-1:0] px_r, py_r;
  logic                   last_r, done_r;

  logic [1:0]             kind_bits;
  mcr_kind_t              kind;
  logic [MCR_COORD_W-1:0] org_x, org_y;
  logic [RADIUS_BITS-1:0] off_x, off_y, off_a, off_b;
  logic [2:0]             last_idx;
  logic                   load_out, finish, out_take;
  logic [SW-1:0]          ox_e, oy_e, a_e, b_e, px_w, py_w;

  assign {kind_bits, org_x, org_y, off_x, off_y} = cmd_r;
  assign kind = mcr_kind_t'(kind_bits);

  always_comb begin
    case (kind)
      KIND_FULL:  last_idx = MCR_LAST_FULL;
      KIND_FINAL: last_idx = MCR_LAST_FINAL;
      KIND_ZERO:  last_idx = MCR_LAST_ZERO;
      default:    last_idx = MCR_LAST_ZERO;
    endcase
  end

  // Bit 2 of the index swaps the offsets, bits 1 and 0 negate x and y.
  assign off_a = idx_r[2] ? off_y : off_x;
  assign off_b = idx_r[2] ? off_x : off_y;
  assign ox_e  = SW'(signed'(org_x));
  assign oy_e  = SW'(signed'(org_y));
  assign a_e   = SW'(off_a);
  assign b_e   = SW'(off_b);
  assign px_w  = idx_r[1] ? (ox_e - a_e) : (ox_e + a_e);
  assign py_w  = idx_r[0] ? (oy_e - b_e) : (oy_e + b_e);

  assign out_take = pop && out_valid_r;
  assign load_out = cmd_valid_r && (!out_valid_r || out_take);
  assign finish   = load_out && (idx_r == last_idx);
  assign q_pop    = !qstat.empty && (!cmd_valid_r || finish);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cmd_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (finish) begin
        cmd_valid_r <= 1'b0;
      end else if (load_out) begin
        idx_r <= idx_r + 3'd1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_rdata;
    end
    if (load_out) begin
      px_r   <= px_w[MCR_POINT_W-1:0];
      py_r   <= py_w[MCR_POINT_W-1:0];
      last_r <= (idx_r == last_idx);
      done_r <= (idx_r == last_idx) && (kind != KIND_FULL);
    end
  end

  assign empty           = !out_valid_r;
  assign out_point_x     = px_r;
  assign out_point_y     = py_r;
  assign out_step_last   = last_r;
  assign out_circle_done = done_r;

endmodule

// ===== test/midpoint_circle_rasterizer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit_tb
// Self-checking bench for the midpoint circle point generator. Start and
// advance requests go in through the push side. Every point that comes out is
// checked against a behavioral circle tracer that runs in lockstep with the
// accepted requests. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit_tb;
  import mcr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEC_W           = MCR_RADIUS_BITS + MCR_DEC_EXTRA;
  localparam int OFF_W           = MCR_RADIUS_BITS + 1;
  localparam int RANDOM_REQUESTS = 450;
  localparam int DRAIN_CYCLES    = 64;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int REPORT_LIMIT    = 10;
  localparam int DIR_ROWS        = 25;
  // A table row with this count takes its points from the tracer.
  localparam int PREDICT         = -1;

  // One generated point, laid out as the result ports carry it.
  typedef struct packed {
    logic signed [MCR_POINT_W-1:0] x;
    logic signed [MCR_POINT_W-1:0] y;
    logic                          last;
    logic                          done;
  } point_t;

  // One directed request. Rows with a count of zero or one carry the
  // expected outcome directly; one point always closes the circle.
  typedef struct {
    logic                       mode;
    logic [MCR_COORD_W-1:0]     cx;
    logic [MCR_COORD_W-1:0]     cy;
    logic [MCR_RADIUS_BITS-1:0] rad;
    int                         exp_n;
    logic [MCR_POINT_W-1:0]     ex;
    logic [MCR_POINT_W-1:0]     ey;
  } dir_row_t;

  logic                          clk             = 1'b0;
  logic                          rst_n           = 1'b0;
  logic                          push            = 1'b0;
  logic                          full;
  logic                          in_mode         = MODE_START;
  logic signed [MCR_COORD_W-1:0] in_center_x     = '0;
  logic signed [MCR_COORD_W-1:0] in_center_y     = '0;
  logic [MCR_RADIUS_BITS-1:0]    in_radius       = '0;
  logic                          empty;
  logic                          pop             = 1'b0;
  logic signed [MCR_POINT_W-1:0] out_point_x;
  logic signed [MCR_POINT_W-1:0] out_point_y;
  logic                          out_step_last;
  logic                          out_circle_done;

  // Tracer state: a private copy of the circle the block should be drawing.
  logic [OFF_W-1:0]              circ_off_x  = '0;
  logic [OFF_W-1:0]              circ_off_y  = '0;
  logic signed [DEC_W-1:0]       circ_dec    = '0;
  logic signed [MCR_COORD_W-1:0] circ_org_x  = '0;
  logic signed [MCR_COORD_W-1:0] circ_org_y  = '0;
  logic                          circ_active = 1'b0;

  point_t pending_points[$];
  int     mismatch_count = 0;
  int     live_requests  = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;

  // Directed part: idle advances, the coordinate and radius extremes, a
  // restart over a live circle, radius zero and small circles run to the end.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{MODE_ADVANCE, 12'h000, 12'h000, 10'h000, 0,       13'h0000, 13'h0000},
    '{MODE_START,   12'h7FF, 12'h800, 10'h000, 0,       13'h0000, 13'h0000},
    '{MODE_ADVANCE, 12'hFFF, 12'hFFF, 10'h3FF, 1,       13'h07FF, 13'h1800},
    '{MODE_ADVANCE, 12'h000, 12'h000, 10'h000, 0,       13'h0000, 13'h0000},
    '{MODE_START,   12'h800, 12'h7FF, 10'h3FF, 0,       13'h0000, 13'h0000},
    '{MODE_ADVANCE, 12'h000, 12'h000, 10'h000, PREDICT, 13'h0000, 13'h0000},
    '{MODE_ADVANCE, 12'h000, 12'h000, 10'h000, PREDICT, 13'h0000, 13'h0000},
    '{MODE_START,   12'h7FF, 12'h7FF, 10'h3FF, 0,       13'h0000, 13'h0000},
    '{MODE_ADVANCE, 12'h000, 12'h000, 10'h000, PREDICT, 13'h0000, 13'h0000},
    '{MODE_ADVANCE, 12'h000, 12'h000, 10'h000, PREDICT, 13'h0000, 13'h0000},
    '{MODE_START,   12'h800, 12'h800, 10'h3FF, 0,       13'h0000, 13'h0000},
    '{MODE_ADVANCE, 12'h000, 12'h000, 10'h000, PREDICT, 13'h0000, 13'h0000},
    '{MODE_START,   12'h000, 12'h000, 10'h001, 0,       13'h0000, 13'h0000},
    '{MODE_ADVANCE, 12'h000, 12'h000, 10'h000, PREDICT, 13'h0000, 13'h0000},
    '{MODE_ADVANCE, 12'h000, 12'h000, 10'h000, PREDICT, 13'h0000, 13'h0000},
    '{MODE_ADVANCE, 12'h000, 12'h000, 10'h000, 0,       13'h0000, 13'h0000},
    '{MODE_START,   12'h005, 12'hFF9, 10'h002, 0,       13'h0000, 13'h0000},
    '{MODE_ADVANCE, 12'h000, 12'h000, 10'h000, PREDICT, 13'h0000, 13'h0000},
    '{MODE_ADVANCE, 12'h000, 12'h000, 10'h000, PREDICT, 13'h0000, 13'h0000},
    '{MODE_ADVANCE, 12'h000, 12'h000, 10'h000, PREDICT, 13'h0000, 13'h0000},
    '{MODE_ADVANCE, 12'h000, 12'h000, 10'h000, 0,       13'h0000, 13'h0000},
    '{MODE_START,   12'hAAA, 12'h555, 10'h2AA, 0,       13'h0000, 13'h0000},
    '{MODE_ADVANCE, 12'h000, 12'h000, 10'h000, PREDICT, 13'h0000, 13'h0000},
    '{MODE_START,   12'h555, 12'hAAA, 10'h155, 0,       13'h0000, 13'h0000},
    '{MODE_ADVANCE, 12'h000, 12'h000, 10'h000, PREDICT, 13'h0000, 13'h0000}
  };

  midpoint_circle_rasterizer_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_mode         (in_mode),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_radius       (in_radius),
    .empty           (empty),
    .pop             (pop),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_step_last   (out_step_last),
    .out_circle_done (out_circle_done)
  );

  always #5 clk = ~clk;

  // Places a point relative to nothing; coordinates wrap to the port width.
  function automatic point_t place_point(int px, int py);
    point_t p;
    p.x    = MCR_POINT_W'(px);
    p.y    = MCR_POINT_W'(py);
    p.last = 1'b0;
    p.done = 1'b0;
    return p;
  endfunction

  // Applies one accepted request to the tracer and returns the points it
  // should produce, in the block's mirror order.
  task automatic trace_circle_step(input logic mode,
                                   input logic signed [MCR_COORD_W-1:0] cx,
                                   input logic signed [MCR_COORD_W-1:0] cy,
                                   input logic [MCR_RADIUS_BITS-1:0] rad,
                                   output point_t pts [8], output int n);
    int x, y, ox, oy;
    n = 0;
    if (mode == MODE_START) begin
      // A start drops whatever circle was in flight.
      circ_org_x  = cx;
      circ_org_y  = cy;
      circ_off_x  = '0;
      circ_off_y  = OFF_W'(rad);
      circ_dec    = DEC_W'(1 - int'(rad));
      circ_active = 1'b1;
      return;
    end
    if (!circ_active) return;
    x  = int'(circ_off_x);
    y  = int'(circ_off_y);
    ox = int'(circ_org_x);
    oy = int'(circ_org_y);
    if (x == 0 && y == 0) begin
      // Radius zero: the center alone closes the circle.
      pts[0]      = place_point(ox, oy);
      pts[0].last = 1'b1;
      pts[0].done = 1'b1;
      n           = 1;
      circ_active = 1'b0;
      return;
    end
    pts[0] = place_point(ox + x, oy + y);
    pts[1] = place_point(ox + x, oy - y);
    pts[2] = place_point(ox - x, oy + y);
    pts[3] = place_point(ox - x, oy - y);
    if (y > x) begin
      pts[4] = place_point(ox + y, oy + x);
      pts[5] = place_point(ox + y, oy - x);
      pts[6] = place_point(ox - y, oy + x);
      pts[7] = place_point(ox - y, oy - x);
      n      = 8;
      if (circ_dec >= 0) begin
        circ_dec   = DEC_W'(int'(circ_dec) + 2 * (x - y) + 5);
        circ_off_y = OFF_W'(y - 1);
      end else begin
        circ_dec = DEC_W'(int'(circ_dec) + 2 * x + 3);
      end
      circ_off_x  = OFF_W'(x + 1);
      pts[7].last = 1'b1;
    end else begin
      // The closing step gives the first four mirrors and ends the circle.
      n           = 4;
      pts[3].last = 1'b1;
      pts[3].done = 1'b1;
      circ_active = 1'b0;
    end
  endtask

  // Drives one request and holds it until the block takes it. The task is
  // entered and left at a falling edge, so push stays high between
  // back-to-back requests and only drops when a sender gap is drawn. When
  // exp_n is not PREDICT, the expected outcome comes from the caller and the
  // tracer only keeps its state in step.
  task automatic send_request(input logic mode,
                              input logic [MCR_COORD_W-1:0] cx,
                              input logic [MCR_COORD_W-1:0] cy,
                              input logic [MCR_RADIUS_BITS-1:0] rad,
                              input int exp_n,
                              input logic [MCR_POINT_W-1:0] ex,
                              input logic [MCR_POINT_W-1:0] ey);
    point_t pts [8];
    point_t p;
    int     n;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push        = 1'b1;
    in_mode     = mode;
    in_center_x = cx;
    in_center_y = cy;
    in_radius   = rad;
    // Full is sampled at the rising edge, before the block updates it.
    do @(posedge clk); while (full);
    // Advances with no circle loaded are ignored by the block and do not
    // count toward the random request budget.
    if (mode == MODE_START || circ_active) live_requests++;
    trace_circle_step(mode, cx, cy, rad, pts, n);
    if (exp_n == PREDICT) begin
      for (int i = 0; i < n; i++) pending_points.push_back(pts[i]);
    end else if (exp_n == 1) begin
      p.x    = ex;
      p.y    = ey;
      p.last = 1'b1;
      p.done = 1'b1;
      pending_points.push_back(p);
    end
    @(negedge clk);
  endtask

  // The receiver decides at each falling edge whether to take a point at the
  // next rising edge.
  always @(negedge clk) begin
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Every point taken is matched, field by field, against the oldest
  // expectation still waiting.
  always @(posedge clk) begin
    point_t want;
    if (rst_n && pop && !empty) begin
      if (pending_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected point: x=%0d y=%0d last=%b done=%b", out_point_x,
                   out_point_y, out_step_last, out_circle_done);
      end else begin
        want = pending_points.pop_front();
        if (out_point_x !== want.x || out_point_y !== want.y ||
            out_step_last !== want.last || out_circle_done !== want.done) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("point mismatch: expected x=%0d y=%0d last=%b done=%b, got x=%0d y=%0d last=%b done=%b",
                     want.x, want.y, want.last, want.done, out_point_x, out_point_y,
                     out_step_last, out_circle_done);
        end
      end
    end
  end

  // Stimulus: reset, the directed table, then random circles across four
  // idling phases, then a drain of the remaining points.
  initial begin
    int                         first_live;
    int                         phase;
    int                         steps;
    int                         cap;
    int                         pick;
    logic [MCR_RADIUS_BITS-1:0] rad;

    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_request(dir_tab[i].mode, dir_tab[i].cx, dir_tab[i].cy, dir_tab[i].rad,
                   dir_tab[i].exp_n, dir_tab[i].ex, dir_tab[i].ey);

    first_live = live_requests;
    while (live_requests - first_live < RANDOM_REQUESTS) begin
      // The phase follows progress through the random budget: free running,
      // a mostly idle sender, a mostly stalled receiver, then both lightly.
      phase = (live_requests - first_live) * 4 / RANDOM_REQUESTS;
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase

      if ($urandom_range(0, 9) < 8) begin
        // A well-formed circle: a start with a mostly small radius, then
        // advances until it closes. Large circles and an occasional broken
        // sequence are cut short by the next start.
        pick = $urandom_range(0, 99);
        if (pick < 10)      rad = MCR_RADIUS_BITS'($urandom_range(0, 3));
        else if (pick < 75) rad = MCR_RADIUS_BITS'($urandom_range(4, 24));
        else if (pick < 95) rad = MCR_RADIUS_BITS'($urandom_range(25, 120));
        else if ($urandom_range(0, 3) == 0) rad = '1;
        else                rad = MCR_RADIUS_BITS'($urandom_range(121, 1023));
        send_request(MODE_START, MCR_COORD_W'($urandom()), MCR_COORD_W'($urandom()),
                     rad, PREDICT, '0, '0);
        cap = (rad > 120) ? $urandom_range(5, 40) : 4096;
        if ($urandom_range(0, 9) == 0) cap = $urandom_range(0, 3);
        steps = 0;
        while (circ_active && steps < cap) begin
          send_request(MODE_ADVANCE, MCR_COORD_W'($urandom()), MCR_COORD_W'($urandom()),
                       MCR_RADIUS_BITS'($urandom()), PREDICT, '0, '0);
          steps++;
        end
      end else begin
        // Noise: any mode with any fields, including advances after the end.
        send_request(1'($urandom()), MCR_COORD_W'($urandom()), MCR_COORD_W'($urandom()),
                     MCR_RADIUS_BITS'($urandom()), PREDICT, '0, '0);
      end
    end

    push           = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < DRAIN_LIMIT && pending_points.size() != 0; i++) @(posedge clk);
    if (pending_points.size() != 0) begin
      mismatch_count += pending_points.size();
      $display("%0d expected points never arrived", pending_points.size());
    end
    // Let any stray point surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("midpoint_circle_rasterizer_unit_tb OK");
    end else begin
      $display("midpoint_circle_rasterizer_unit_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(5_000_000);
    $display("midpoint_circle_rasterizer_unit_tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mcr_pkg.sv
rtl/mcr_front.sv
rtl/mcr_queue.sv
rtl/mcr_back.sv
rtl/midpoint_circle_rasterizer_unit.sv
test/midpoint_circle_rasterizer_unit_tb.sv
